### sv/bitmap_slot_allocator_macros.svh
// Assertion macros for the slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define BSA_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define BSA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

### sv/bsa_pkg.sv
// Shared types and constants for the slot allocator
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int Pages = 8;
  localparam int Slots = 128;
  localparam int PageW = $clog2(Pages);
  localparam int SlotW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);
  localparam int LenW = $clog2(Pages + 1);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_RECLAIM = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_PAGE = 3'd1;
  localparam logic [2:0] ST_NOT_IN_USE = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_DOUBLE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_FREE, S_RECL, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic alloc;     // perform allocate
    logic free;      // perform free
    logic recl_step; // examine one list entry
    logic finish;    // latch result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic recl_done;
  } stat_t;
endpackage

### sv/bsa_if.sv
// Valid/ready channel interfaces
`timescale 1ns / 1ps
interface bsa_req_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [2:0] page_id;
  logic [6:0] slot_index;
  modport source (output valid, kind, page_id, slot_index, input ready);
  modport sink (input valid, kind, page_id, slot_index, output ready);
endinterface

interface bsa_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [2:0] granted_page;
  logic [6:0] granted_slot;
  logic [3:0] pages_released;
  modport source (output valid, status, granted_page, granted_slot, pages_released,
    input ready);
  modport sink (input valid, status, granted_page, granted_slot, pages_released,
    output ready);
endinterface

interface bsa_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/bsa_ctrl.sv
// Controller state machine for the slot allocator
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_macros.svh"
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  output logic             out_valid,
  input  logic             out_ready,
  input  bsa_pkg::stat_t   stat,
  output bsa_pkg::cmd_t    cmd
);
  bsa_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            bsa_pkg::KIND_ALLOC: state_nxt = bsa_pkg::S_ALLOC;
            bsa_pkg::KIND_FREE: state_nxt = bsa_pkg::S_FREE;
            bsa_pkg::KIND_RECLAIM: state_nxt = bsa_pkg::S_RECL;
            default: state_nxt = bsa_pkg::S_DONE;
          endcase
        end
      end
      bsa_pkg::S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = bsa_pkg::S_DONE;
      end
      bsa_pkg::S_FREE: begin
        cmd.free = 1'b1;
        state_nxt = bsa_pkg::S_DONE;
      end
      bsa_pkg::S_RECL: begin
        if (stat.recl_done) state_nxt = bsa_pkg::S_DONE;
        else cmd.recl_step = 1'b1;
      end
      bsa_pkg::S_DONE: begin
        // wait for the previous result to drain
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = bsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsa_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `BSA_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == bsa_pkg::S_IDLE, "ready")
  `BSA_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_r, "finish")
  `BSA_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping commands")
endmodule

### sv/bsa_dp.sv
// Datapath: page tables, free list and result register
`timescale 1ns / 1ps
module bsa_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsa_pkg::cmd_t         cmd,
  output bsa_pkg::stat_t        stat,
  input  logic [2:0]            in_page_id,
  input  logic [6:0]            in_slot_index,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  output logic [2:0]            status,
  output logic [2:0]            granted_page,
  output logic [6:0]            granted_slot,
  output logic [3:0]            pages_released
);
  localparam int P = bsa_pkg::Pages;
  localparam int S = bsa_pkg::Slots;
  localparam int PW = bsa_pkg::PageW;
  localparam int SW = bsa_pkg::SlotW;
  localparam int CW = bsa_pkg::CntW;
  localparam int LW = bsa_pkg::LenW;

  logic [S-1:0]  bitmap_r [P];
  logic [CW-1:0] count_r [P];
  logic [P-1:0]  in_use_r;
  logic [PW-1:0] order_r [P];
  logic [LW-1:0] len_r;
  logic [7:0]    spp_r;
  logic [PW-1:0] page_q_r;
  logic [SW-1:0] slot_q_r;
  logic [LW-1:0] idx_r;
  logic [3:0]    rel_r;
  logic [2:0]    st_r;
  logic [PW-1:0] gp_r;
  logic [SW-1:0] gs_r;
  logic [2:0]    o_st_r;
  logic [PW-1:0] o_gp_r;
  logic [SW-1:0] o_gs_r;
  logic [3:0]    o_rel_r;

  logic [CW-1:0] eff;
  logic          have_unused;
  logic [PW-1:0] unused_p;
  logic [S-1:0]  fill_mask;
  logic [PW-1:0] head;
  logic [S-1:0]  head_map;
  logic          found;
  logic [SW-1:0] found_k;
  logic [PW-1:0] rp;

  // clamp slot count register
  always_comb begin
    if (spp_r == 8'd0) eff = CW'(1);
    else if (32'(spp_r) > S) eff = CW'(S);
    else eff = CW'(spp_r);
  end

  // lowest unused page and initial fill pattern
  always_comb begin
    have_unused = 1'b0;
    unused_p = '0;
    for (int p = P - 1; p >= 0; p--) begin
      if (!in_use_r[p]) begin
        have_unused = 1'b1;
        unused_p = PW'(p);
      end
    end
    for (int k = 0; k < S; k++) fill_mask[k] = (32'(k) < 32'(eff));
  end

  // head page bitmap and lowest set bit
  always_comb begin
    head = (len_r == '0) ? unused_p : order_r[0];
    head_map = (len_r == '0) ? fill_mask : bitmap_r[head];
    found = 1'b0;
    found_k = '0;
    for (int k = S - 1; k >= 0; k--) begin
      if (head_map[k]) begin
        found = 1'b1;
        found_k = SW'(k);
      end
    end
  end

  assign rp = order_r[idx_r[PW-1:0]];
  assign stat.recl_done = (idx_r >= len_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) spp_r <= 8'd128;
    else if (cfg_we) spp_r <= cfg_data;
  end

  // request execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.load) begin
        page_q_r <= in_page_id[PW-1:0];
        slot_q_r <= in_slot_index[SW-1:0];
        idx_r <= '0;
        rel_r <= '0;
        st_r <= bsa_pkg::ST_OK;
        gp_r <= '0;
        gs_r <= '0;
      end
      if (cmd.alloc) begin
        if (len_r == '0 && !have_unused) begin
          st_r <= bsa_pkg::ST_NO_PAGE;
        end else begin
          logic [CW-1:0] c;
          logic [LW-1:0] l;
          logic [P-1:0] iu;
          c = (len_r == '0) ? eff : count_r[head];
          l = (len_r == '0) ? LW'(1) : len_r;
          iu = in_use_r;
          iu[head] = 1'b1;
          in_use_r <= iu;
          if (!found) begin
            count_r[head] <= '0;
            bitmap_r[head] <= head_map;
            st_r <= bsa_pkg::ST_NO_PAGE;
            c = '0;
          end else begin
            logic [S-1:0] m;
            m = head_map;
            m[found_k] = 1'b0;
            bitmap_r[head] <= m;
            if (c != '0) c = c - CW'(1);
            count_r[head] <= c;
            gp_r <= head;
            gs_r <= found_k;
          end
          // drop a full head page, else keep a newly used page at the head
          if (c == '0) begin
            for (int i = 0; i < P - 1; i++) order_r[i] <= order_r[i + 1];
            len_r <= l - LW'(1);
          end else begin
            if (len_r == '0) order_r[0] <= head;
            len_r <= l;
          end
        end
      end
      if (cmd.free) begin
        if (!in_use_r[page_q_r]) st_r <= bsa_pkg::ST_NOT_IN_USE;
        else if (CW'(slot_q_r) >= eff) st_r <= bsa_pkg::ST_RANGE;
        else if (bitmap_r[page_q_r][slot_q_r] || count_r[page_q_r] >= eff)
          st_r <= bsa_pkg::ST_DOUBLE;
        else begin
          bitmap_r[page_q_r][slot_q_r] <= 1'b1;
          count_r[page_q_r] <= count_r[page_q_r] + CW'(1);
          if (count_r[page_q_r] == '0 && 32'(len_r) < P) begin
            order_r[len_r[PW-1:0]] <= page_q_r;
            len_r <= len_r + LW'(1);
          end
        end
      end
      if (cmd.recl_step) begin
        if (count_r[rp] == eff) begin
          for (int i = 0; i < P - 1; i++)
            if (32'(i) >= 32'(idx_r)) order_r[i] <= order_r[i + 1];
          len_r <= len_r - LW'(1);
          in_use_r[rp] <= 1'b0;
          rel_r <= rel_r + 4'd1;
        end else begin
          idx_r <= idx_r + LW'(1);
        end
      end
      if (cmd.finish) begin
        o_st_r <= st_r;
        o_gp_r <= gp_r;
        o_gs_r <= gs_r;
        o_rel_r <= rel_r;
      end
    end
  end

  assign status = o_st_r;
  assign granted_page = 3'(o_gp_r);
  assign granted_slot = 7'(o_gs_r);
  assign pages_released = o_rel_r;
endmodule

### sv/bitmap_slot_allocator.sv
// Top level: slot allocator over a pool of pages
// Allocate and free pass through S_ALLOC or S_FREE, then S_DONE, which registers the
// result; reclaim stays in S_RECL until it has walked the free list; an unused kind
// goes straight to S_DONE. One request in flight; a new request is accepted only in
// S_IDLE, and a result held by the sink stalls the next request's result.
// Reset clears page usage, the free list and out_valid; slot count resets to 128.
`timescale 1ns / 1ps
module bitmap_slot_allocator (
  input logic    clk,
  input logic    rst_n,
  bsa_req_if.sink in_ch,
  bsa_rsp_if.source out_ch,
  bsa_cfg_if.sink cfg_ch
);
  bsa_pkg::cmd_t  cmd;
  bsa_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  bsa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_page_id(in_ch.page_id), .in_slot_index(in_ch.slot_index),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .status(out_ch.status), .granted_page(out_ch.granted_page),
    .granted_slot(out_ch.granted_slot), .pages_released(out_ch.pages_released)
  );
endmodule
